[rtl/msq_pkg.sv]
package msq_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_UPDATE     = 2'd0;
    localparam logic [1:0] CMD_ENTER_TEST = 2'd1;
    localparam logic [1:0] CMD_EXIT_TEST  = 2'd2;

    // Configuration register indexes
    localparam int          CFG_ADDR_W      = 1;
    localparam int          CFG_DATA_W      = 32;
    localparam logic [0:0]  CFG_FORCE_LIMIT = 1'd0;
    localparam logic [0:0]  CFG_DURATION    = 1'd1;

    localparam logic signed [15:0] FORCE_LIMIT_RST = 16'sd32767;
    localparam logic        [31:0] DURATION_RST    = 32'hFFFF_FFFF;

    // Stream widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // Phase codes as they appear on the result stream
    localparam logic [2:0] CODE_PRELAUNCH  = 3'd0;
    localparam logic [2:0] CODE_ARMED      = 3'd1;
    localparam logic [2:0] CODE_ASCENT     = 3'd2;
    localparam logic [2:0] CODE_EXPERIMENT = 3'd3;
    localparam logic [2:0] CODE_SAFE       = 3'd4;
    localparam logic [2:0] CODE_ABORT      = 3'd5;
    localparam logic [2:0] CODE_TEST       = 3'd6;

    // Mission phase, one-hot
    typedef enum logic [6:0] {
        PH_PRELAUNCH  = 7'b000_0001,
        PH_ARMED      = 7'b000_0010,
        PH_ASCENT     = 7'b000_0100,
        PH_EXPERIMENT = 7'b000_1000,
        PH_SAFE       = 7'b001_0000,
        PH_ABORT      = 7'b010_0000,
        PH_TEST       = 7'b100_0000
    } t_phase;

    // One input transaction, unpacked
    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        now_ms;
        logic               op_abort;
        logic signed [15:0] force_load;
        logic               storage_start;
        logic               lift_off;
        logic               experiment_start;
    } t_item;

    // Configuration register contents
    typedef struct packed {
        logic signed [15:0] force_limit;
        logic [31:0]        experiment_duration_ms;
    } t_cfg;

    // Outcome of one step
    typedef struct packed {
        t_phase      next_phase;
        logic        load_start_time;
        logic        accepted;
    } t_step_res;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        code = CODE_PRELAUNCH;
        case (ph)
            PH_PRELAUNCH:  code = CODE_PRELAUNCH;
            PH_ARMED:      code = CODE_ARMED;
            PH_ASCENT:     code = CODE_ASCENT;
            PH_EXPERIMENT: code = CODE_EXPERIMENT;
            PH_SAFE:       code = CODE_SAFE;
            PH_ABORT:      code = CODE_ABORT;
            PH_TEST:       code = CODE_TEST;
            default:       code = CODE_PRELAUNCH;
        endcase
        return code;
    endfunction

endpackage

[rtl/msq_cfg_regs.sv]
module msq_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [msq_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [msq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output msq_pkg::t_cfg                      o_cfg
);

    logic signed [15:0] r_force_limit;
    logic        [31:0] r_duration;

    // Hold register values, load on a write to the matching index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_limit <= msq_pkg::FORCE_LIMIT_RST;
            r_duration    <= msq_pkg::DURATION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                msq_pkg::CFG_FORCE_LIMIT: r_force_limit <= signed'(i_cfg_wdata[15:0]);
                msq_pkg::CFG_DURATION:    r_duration    <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.force_limit            = r_force_limit;
    assign o_cfg.experiment_duration_ms = r_duration;

endmodule

[rtl/msq_step.sv]
module msq_step (
    input  msq_pkg::t_item     i_item,
    input  msq_pkg::t_phase    i_phase,
    input  logic [31:0]        i_start_time,
    input  msq_pkg::t_cfg      i_cfg,
    output msq_pkg::t_step_res o_res
);

    logic [31:0]     w_elapsed;
    logic            w_over_force;
    logic            w_done;
    msq_pkg::t_phase w_upd_phase;
    logic            w_upd_load;

    // Wrapping elapsed time and the two experiment checks
    assign w_elapsed    = i_item.now_ms - i_start_time;
    assign w_done       = (w_elapsed >= i_cfg.experiment_duration_ms);
    assign w_over_force = (i_item.force_load > i_cfg.force_limit);

    // Update command: abort first, then the flight sequence
    always_comb begin
        w_upd_phase = i_phase;
        w_upd_load  = 1'b0;
        if (i_phase != msq_pkg::PH_SAFE && i_phase != msq_pkg::PH_ABORT
            && i_item.op_abort) begin
            w_upd_phase = msq_pkg::PH_ABORT;
        end else if (i_phase == msq_pkg::PH_EXPERIMENT && w_over_force) begin
            w_upd_phase = msq_pkg::PH_ABORT;
        end else begin
            case (i_phase)
                msq_pkg::PH_PRELAUNCH,
                msq_pkg::PH_TEST: begin
                    if (i_item.storage_start) w_upd_phase = msq_pkg::PH_ARMED;
                end
                msq_pkg::PH_ARMED: begin
                    if (i_item.lift_off) w_upd_phase = msq_pkg::PH_ASCENT;
                end
                msq_pkg::PH_ASCENT: begin
                    if (i_item.experiment_start) begin
                        w_upd_phase = msq_pkg::PH_EXPERIMENT;
                        w_upd_load  = 1'b1;
                    end
                end
                msq_pkg::PH_EXPERIMENT: begin
                    if (w_done) w_upd_phase = msq_pkg::PH_SAFE;
                end
                default: ;
            endcase
        end
    end

    // Select by command; test requests only from the matching phase
    always_comb begin
        o_res.next_phase      = i_phase;
        o_res.load_start_time = 1'b0;
        o_res.accepted        = 1'b0;
        unique case (i_item.command)
            msq_pkg::CMD_UPDATE: begin
                o_res.next_phase      = w_upd_phase;
                o_res.load_start_time = w_upd_load;
                o_res.accepted        = 1'b1;
            end
            msq_pkg::CMD_ENTER_TEST: begin
                if (i_phase == msq_pkg::PH_PRELAUNCH) begin
                    o_res.next_phase = msq_pkg::PH_TEST;
                    o_res.accepted   = 1'b1;
                end
            end
            msq_pkg::CMD_EXIT_TEST: begin
                if (i_phase == msq_pkg::PH_TEST) begin
                    o_res.next_phase = msq_pkg::PH_PRELAUNCH;
                    o_res.accepted   = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/mission_phase_sequencer.sv]
// Mission phase sequencer.
// Input stream: one transaction per command. tuser carries the command
// (update, enter test, exit test); tdata carries the timestamp, the abort
// flag, the load force and the three event flags of an update.
// Output stream: exactly one result per input transaction with the phase
// after the step, a phase-changed flag and the accepted flag.
// Configuration: plain write port, index 0 force limit, index 1 experiment
// duration in ms; write only while no transaction is in flight.
// Pipeline: a transaction accepted at one clock edge is registered in the
// input register; its result is registered in the result register when it
// advances. Throughput: one transaction per cycle unless the result stalls,
// set by the single phase register that every step reads and writes.
// Stall: the result register holds while the receiver is not ready; the input
// register still takes one more transaction, after which tready drops.
// Reset: phase returns to pre-launch, experiment start time to zero, both
// configuration registers to their maximum values, both stages empty.
module mission_phase_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] now_ms, [32] op_abort, [48:33] force_load,
    // [49] storage_start, [50] lift_off, [51] experiment_start, [55:52] zero
    input  logic [msq_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // [1:0] command
    input  logic [msq_pkg::IN_USER_W-1:0]       i_s_axis_tuser,
    // Output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [2:0] phase, [3] phase_changed, [4] accepted, [7:5] zero
    output logic [msq_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [msq_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [msq_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    msq_pkg::t_cfg      w_cfg;
    msq_pkg::t_step_res w_res;
    msq_pkg::t_item     w_in_item;

    logic               r_in_valid;
    msq_pkg::t_item     r_in_item;
    logic               r_out_valid;
    logic [2:0]         r_out_phase;
    logic               r_out_changed;
    logic               r_out_accepted;
    msq_pkg::t_phase    r_phase;
    logic [31:0]        r_start_time;

    logic               w_advance;
    logic               w_in_take;

    msq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    msq_step u_step (
        .i_item       (r_in_item),
        .i_phase      (r_phase),
        .i_start_time (r_start_time),
        .i_cfg        (w_cfg),
        .o_res        (w_res)
    );

    // Unpack the incoming transaction
    assign w_in_item.command          = i_s_axis_tuser;
    assign w_in_item.now_ms           = i_s_axis_tdata[31:0];
    assign w_in_item.op_abort         = i_s_axis_tdata[32];
    assign w_in_item.force_load       = signed'(i_s_axis_tdata[48:33]);
    assign w_in_item.storage_start    = i_s_axis_tdata[49];
    assign w_in_item.lift_off         = i_s_axis_tdata[50];
    assign w_in_item.experiment_start = i_s_axis_tdata[51];

    // Advance when the result register is free or being drained
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= w_in_item;
        end
    end

    // Mission state, updated as each transaction passes to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= msq_pkg::PH_PRELAUNCH;
            r_start_time <= 32'd0;
        end else if (w_advance) begin
            r_phase <= w_res.next_phase;
            if (w_res.load_start_time) begin
                r_start_time <= r_in_item.now_ms;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_phase    <= msq_pkg::phase_code(w_res.next_phase);
            r_out_changed  <= (w_res.next_phase != r_phase);
            r_out_accepted <= w_res.accepted;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_accepted, r_out_changed, r_out_phase};

    // Phase register stays one-hot
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register not one-hot");

    // Safe and abort are final outside reset
    a_final_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && ($past(r_phase) == msq_pkg::PH_SAFE
                           || $past(r_phase) == msq_pkg::PH_ABORT)
        |-> r_phase == $past(r_phase))
        else $error("left a final phase");

    // Phase moves only when a transaction advances
    a_phase_by_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_phase))
        else $error("phase changed without a transaction");

    // A rejected request never changes the phase
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_accepted |-> !r_out_changed)
        else $error("rejected request changed phase");

    // A new result appears only after an advance
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance))
        else $error("result without a transaction");

endmodule
